/* hw/rtl/nearest_other_id_point_search_defines.svh */
// Assertion macros for the nearest other-id point search.
`ifndef NEAREST_OTHER_ID_POINT_SEARCH_DEFINES_SVH
`define NEAREST_OTHER_ID_POINT_SEARCH_DEFINES_SVH

// Implication in the same cycle, disabled while rst_n is low.
`define NOI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define NOI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/noisrch_pkg.sv */
`default_nettype none
package noisrch_pkg;
    localparam int MaxPoints = 1024;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CntW      = AddrW + 1;
    localparam int PointW    = 48;

    localparam logic [1:0] ReqClear  = 2'd0;
    localparam logic [1:0] ReqAppend = 2'd1;
    localparam logic [1:0] ReqQuery  = 2'd2;
    localparam logic [1:0] ReqIgnore = 2'd3;

    localparam logic [1:0] StFound   = 2'd0;
    localparam logic [1:0] StNone    = 2'd1;
    localparam logic [1:0] StBadIdx  = 2'd2;
    // internal: root in progress, never on a valid result beat
    localparam logic [1:0] StRoot    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QLAT, S_DN_RD, S_DN_CHK, S_UP_RD, S_UP_CHK,
        S_MUL, S_ACC, S_SQRT, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [57:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [24:0] root;
    } t_sqrt_rsp;
endpackage
`default_nettype wire

/* hw/rtl/nearest_other_id_point_search.sv */
// Append, clear, ignored request: one beat, ready again the next cycle, no result beat.
// Query: setup latches the query point; each scanned point: RAM read, check, shared
// 16x16 multiplier twice, compare (same-id or pruned: read and check only); then the
// bit-serial root and output register (no root if no other-id point). Bad index: goes
// to S_OUT, then result valid. Ready stays low until the result beat is taken.
// Reset (synchronous, i_rst_n low): point count zero, sequencer idle; RAM kept as is.
`default_nettype none
`include "nearest_other_id_point_search_defines.svh"
module nearest_other_id_point_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [15:0] x_coord, [31:16] y_coord, [47:32] patch_id, [57:48] query_index
    input  wire logic [63:0] i_s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] neighbor_id, [48:16] dist_sq, [73:49] dist_q8
    output logic [79:0]      o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]       o_m_axis_tuser
);
    localparam int AW = noisrch_pkg::AddrW;
    localparam int CW = noisrch_pkg::CntW;
    localparam logic [CW-1:0] MaxCnt = CW'(noisrch_pkg::MaxPoints);

    noisrch_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_qi, n_qi;
    logic [CW-1:0] r_k, n_k;
    logic          r_dir_up, n_dir_up;
    logic signed [15:0] r_xq, n_xq, r_yq, n_yq;
    logic [15:0]   r_idq, n_idq;
    logic          r_have, n_have, r_side, n_side;
    logic [32:0]   r_best, n_best;
    logic [15:0]   r_best_id, n_best_id;
    logic signed [16:0] r_dx, n_dx, r_dy, n_dy;
    logic [15:0]   r_kid, n_kid;
    logic [32:0]   r_sq, n_sq;
    logic [32:0]   r_acc, n_acc;
    logic [1:0]    r_status, n_status;
    logic [24:0]   r_q8, n_q8;
    logic          r_ovalid, n_ovalid;

    logic          we;
    logic [AW-1:0] raddr;
    logic [noisrch_pkg::PointW-1:0] rdata;
    logic signed [15:0] kx, ky;
    logic [15:0]   kid;
    logic signed [16:0] mul_in;
    logic [15:0]   mul_mag;
    logic [33:0]   mul_out;
    logic          gap_stop;
    noisrch_pkg::t_sqrt_req sq_req;
    noisrch_pkg::t_sqrt_rsp sq_rsp;
    logic          acc_in;
    logic          st_idle;
    logic          st_out;

    assign st_idle = r_state == noisrch_pkg::S_IDLE;
    assign st_out  = r_state == noisrch_pkg::S_OUT;
    assign o_s_axis_tready = st_idle && !r_ovalid;
    assign acc_in = i_s_axis_tvalid && o_s_axis_tready;
    assign we = acc_in && i_s_axis_tuser == noisrch_pkg::ReqAppend && r_count < MaxCnt;

    noisrch_ram #(.Width(noisrch_pkg::PointW), .Depth(noisrch_pkg::MaxPoints)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_s_axis_tdata[47:0]),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    noisrch_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sq_req), .o_rsp(sq_rsp));

    assign kx  = rdata[15:0];
    assign ky  = rdata[31:16];
    assign kid = rdata[47:32];
    // |mul_in| fits 16 bits, so one unsigned 16x16 product
    assign mul_mag = mul_in[16] ? 16'(-mul_in) : mul_in[15:0];
    assign mul_out = {2'b00, {16'd0, mul_mag} * {16'd0, mul_mag}};
    // r_side set, gap >= 0 and gap^2 >= best; mul_in carries gap in S_DN_CHK
    assign gap_stop = r_side && !mul_in[16] && mul_out >= {1'b0, r_best};

    always_comb begin
        n_state = r_state; n_count = r_count; n_qi = r_qi; n_k = r_k;
        n_dir_up = r_dir_up; n_xq = r_xq; n_yq = r_yq; n_idq = r_idq;
        n_have = r_have; n_side = r_side; n_best = r_best; n_best_id = r_best_id;
        n_dx = r_dx; n_dy = r_dy; n_kid = r_kid; n_sq = r_sq; n_acc = r_acc;
        n_status = r_status; n_q8 = r_q8; n_ovalid = r_ovalid;
        raddr = r_k[AW-1:0];
        mul_in = r_dx;
        sq_req.start = 1'b0;
        sq_req.value = {9'd0, r_best, 16'd0};
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            noisrch_pkg::S_IDLE: begin
                raddr = i_s_axis_tdata[48 +: AW];
                if (acc_in) begin
                    unique case (i_s_axis_tuser)
                        noisrch_pkg::ReqClear: n_count = '0;
                        noisrch_pkg::ReqAppend: begin
                            if (we) n_count = r_count + CW'(1);
                        end
                        noisrch_pkg::ReqQuery: begin
                            n_qi = i_s_axis_tdata[48 +: AW];
                            n_have = 1'b0; n_best = '0; n_best_id = '0;
                            if ({1'b0, i_s_axis_tdata[48 +: AW]} >= r_count) begin
                                n_status = noisrch_pkg::StBadIdx;
                                n_state = noisrch_pkg::S_OUT;
                            end else begin
                                n_state = noisrch_pkg::S_QLAT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            noisrch_pkg::S_QLAT: begin
                n_xq = kx; n_yq = ky; n_idq = kid;
                n_side = 1'b0; n_dir_up = 1'b0;
                n_k = {1'b0, r_qi};
                n_state = noisrch_pkg::S_QRD;
            end
            noisrch_pkg::S_QRD: begin
                // advance to next candidate index in the current direction, turning up after index 0
                if (!r_dir_up) begin
                    if (r_k == '0) begin
                        n_dir_up = 1'b1; n_side = 1'b0;
                        n_k = {1'b0, r_qi} + CW'(1);
                        n_state = noisrch_pkg::S_QRD;
                        if ({1'b0, r_qi} + CW'(1) >= r_count) n_state = noisrch_pkg::S_SQRT;
                        else n_state = noisrch_pkg::S_DN_RD;
                    end else begin
                        n_k = r_k - CW'(1);
                        n_state = noisrch_pkg::S_DN_RD;
                    end
                end else begin
                    if (r_k + CW'(1) >= r_count) n_state = noisrch_pkg::S_SQRT;
                    else begin
                        n_k = r_k + CW'(1);
                        n_state = noisrch_pkg::S_DN_RD;
                    end
                end
            end
            noisrch_pkg::S_DN_RD: n_state = noisrch_pkg::S_DN_CHK;
            noisrch_pkg::S_DN_CHK: begin
                n_kid = kid;
                n_dx = 17'(kx) - 17'(r_xq);
                n_dy = 17'(ky) - 17'(r_yq);
                mul_in = r_dir_up ? 17'(kx) - 17'(r_xq) : 17'(r_xq) - 17'(kx);
                if (kid == r_idq) n_state = noisrch_pkg::S_QRD;
                else if (gap_stop) begin
                    if (r_dir_up) n_state = noisrch_pkg::S_SQRT;
                    else begin
                        n_k = '0; n_state = noisrch_pkg::S_QRD;
                    end
                end else n_state = noisrch_pkg::S_MUL;
            end
            noisrch_pkg::S_MUL: begin
                mul_in = r_dx;
                n_sq = mul_out[32:0];
                n_state = noisrch_pkg::S_ACC;
            end
            noisrch_pkg::S_ACC: begin
                mul_in = r_dy;
                n_acc = r_sq + mul_out[32:0];
                n_state = noisrch_pkg::S_UP_CHK;
            end
            noisrch_pkg::S_UP_CHK: begin
                if (!r_have || r_acc < r_best) begin
                    n_have = 1'b1; n_side = 1'b1;
                    n_best = r_acc; n_best_id = r_kid;
                end
                n_state = noisrch_pkg::S_QRD;
            end
            noisrch_pkg::S_UP_RD: n_state = noisrch_pkg::S_SQRT;
            noisrch_pkg::S_SQRT: begin
                if (!r_have) begin
                    n_status = noisrch_pkg::StNone;
                    n_best = '0; n_best_id = '0; n_q8 = '0;
                    n_state = noisrch_pkg::S_OUT;
                end else if (!sq_rsp.busy && !sq_rsp.done
                             && r_status != noisrch_pkg::StRoot) begin
                    sq_req.start = 1'b1;
                    n_status = noisrch_pkg::StRoot;
                end else if (sq_rsp.done) begin
                    n_q8 = sq_rsp.root;
                    n_status = noisrch_pkg::StFound;
                    n_state = noisrch_pkg::S_OUT;
                end
            end
            noisrch_pkg::S_OUT: begin
                if (r_status == noisrch_pkg::StBadIdx) n_q8 = '0;
                n_ovalid = 1'b1;
                n_state = noisrch_pkg::S_IDLE;
            end
            default: n_state = noisrch_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= noisrch_pkg::S_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_status <= noisrch_pkg::StFound;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
            r_status <= n_status;
        end
        r_qi <= n_qi; r_k <= n_k; r_dir_up <= n_dir_up; r_xq <= n_xq; r_yq <= n_yq;
        r_idq <= n_idq; r_have <= n_have; r_side <= n_side; r_best <= n_best;
        r_best_id <= n_best_id; r_dx <= n_dx; r_dy <= n_dy; r_kid <= n_kid;
        r_sq <= n_sq; r_acc <= n_acc; r_q8 <= n_q8;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {6'd0, r_q8, r_best, r_best_id};

    `NOI_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= MaxCnt, "count overflow")
    `NOI_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, !st_idle, !o_s_axis_tready, "ready while busy")
    `NOI_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, st_out, o_m_axis_tvalid, "result lost")
endmodule
`default_nettype wire

/* hw/rtl/noisrch_ram.sv */
`default_nettype none
module noisrch_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/noisrch_sqrt.sv */
`default_nettype none
`include "nearest_other_id_point_search_defines.svh"
// Bit-serial floor square root, one result bit per cycle.
module noisrch_sqrt (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire noisrch_pkg::t_sqrt_req i_req,
    output noisrch_pkg::t_sqrt_rsp     o_rsp
);
    logic [25:0] r_rem, n_rem;
    logic [24:0] r_root, n_root;
    logic [57:0] r_val, n_val;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [27:0] trial;
    logic [27:0] cur;
    logic [27:0] diff;

    always_comb begin
        n_rem = r_rem; n_root = r_root; n_val = r_val;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        cur   = {r_rem, r_val[57:56]};
        trial = {1'b0, r_root, 2'b01};
        diff  = cur - trial;
        if (i_req.start) begin
            n_rem = '0; n_root = '0; n_val = i_req.value;
            n_cnt = 5'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (cur >= trial) begin
                n_rem  = diff[25:0];
                n_root = {r_root[23:0], 1'b1};
            end else begin
                n_rem  = cur[25:0];
                n_root = {r_root[23:0], 1'b0};
            end
            n_val = {r_val[55:0], 2'b00};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd28) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_root <= n_root; r_val <= n_val;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

    `NOI_ASSERT_NEXT(a_done_after_busy, i_clk, i_rst_n, r_done, !r_busy, "sqrt done while busy")
    `NOI_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, r_busy, r_cnt <= 5'd28, "sqrt count overrun")
    `NOI_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy, "sqrt not started")
endmodule
`default_nettype wire
